### sv/hsne_pkg.sv
// ----------------------------------------------------------------------------
// hsne_pkg
// Types, constants and the half-shell slot table for the neighbour enumerator.
// ----------------------------------------------------------------------------
package hsne_pkg;

	localparam int unsigned IDX_W           = 12;
	localparam int unsigned SIZE_W          = 7;
	localparam int unsigned SLOT_W          = 4;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned MAX_GRID_DIM    = 64;
	localparam int unsigned MIN_GRID_DIM    = 3;
	localparam int unsigned GRID_RESET      = 3;
	localparam int unsigned HALF_SHELL_SIZE = 14;
	localparam int unsigned DIV_STAGES      = 3;
	localparam int unsigned DIV_STEPS       = IDX_W / DIV_STAGES;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SIZE_W-1:0] dim_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_X = 2'd0,
		REG_GRID_Y = 2'd1,
		REG_GRID_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ROW_SELF,
		ROW_UP_Y,
		ROW_UP_Z_DN_Y,
		ROW_UP_Z,
		ROW_UP_Z_UP_Y
	} row_t;

	typedef enum logic [1:0] {
		DX_MINUS,
		DX_ZERO,
		DX_PLUS
	} dx_t;

	typedef struct packed {
		row_t row;
		dx_t  dx;
	} shell_step_t;

	typedef struct packed {
		dim_t gx;
		dim_t gy;
		dim_t gz;
		idx_t plane;
		logic ok;
	} grid_cfg_t;

	// restoring divider state: dq shifts dividend bits out and quotient bits in
	typedef struct packed {
		idx_t idx;
		dim_t x;
		dim_t rem;
		idx_t dq;
	} div_t;

	typedef struct packed {
		logic inner;
		idx_t b_self;
		idx_t b_up_y;
		idx_t b_up_z_dn_y;
		idx_t b_up_z;
		idx_t b_up_z_up_y;
	} shell_item_t;

	function automatic dim_t sat_dim(dim_t v);
		return (v > dim_t'(MAX_GRID_DIM)) ? dim_t'(MAX_GRID_DIM) : v;
	endfunction

	function automatic shell_step_t shell_step(slot_t s);
		shell_step_t r;
		case (s)
			4'd0:    r = '{ROW_SELF,      DX_ZERO};
			4'd1:    r = '{ROW_SELF,      DX_PLUS};
			4'd2:    r = '{ROW_UP_Y,      DX_MINUS};
			4'd3:    r = '{ROW_UP_Y,      DX_ZERO};
			4'd4:    r = '{ROW_UP_Y,      DX_PLUS};
			4'd5:    r = '{ROW_UP_Z_DN_Y, DX_MINUS};
			4'd6:    r = '{ROW_UP_Z_DN_Y, DX_ZERO};
			4'd7:    r = '{ROW_UP_Z_DN_Y, DX_PLUS};
			4'd8:    r = '{ROW_UP_Z,      DX_MINUS};
			4'd9:    r = '{ROW_UP_Z,      DX_ZERO};
			4'd10:   r = '{ROW_UP_Z,      DX_PLUS};
			4'd11:   r = '{ROW_UP_Z_UP_Y, DX_MINUS};
			4'd12:   r = '{ROW_UP_Z_UP_Y, DX_ZERO};
			4'd13:   r = '{ROW_UP_Z_UP_Y, DX_PLUS};
			default: r = '{ROW_SELF,      DX_ZERO};
		endcase
		return r;
	endfunction

endpackage

### sv/hsne_if.sv
// ----------------------------------------------------------------------------
// hsne_if
// Valid/ready channels of the neighbour enumerator: cells, neighbours, config.
// ----------------------------------------------------------------------------
interface hsne_cell_if;
	logic          valid;
	logic          ready;
	hsne_pkg::idx_t cell_index;

	modport source (output valid, output cell_index, input ready);
	modport sink   (input valid, input cell_index, output ready);
endinterface

interface hsne_nbr_if;
	logic            valid;
	logic            ready;
	hsne_pkg::idx_t  neighbor_index;
	hsne_pkg::slot_t slot;
	logic            is_inner;
	logic            last;

	modport source (output valid, output neighbor_index, output slot, output is_inner,
		output last, input ready);
	modport sink   (input valid, input neighbor_index, input slot, input is_inner,
		input last, output ready);
endinterface

interface hsne_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [hsne_pkg::CFG_IDX_W-1:0]       index;
	hsne_pkg::dim_t                       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/hsne_cfg_regs.sv
// ----------------------------------------------------------------------------
// hsne_cfg_regs
// Grid size registers, saturated on write, with derived plane size and check.
// ----------------------------------------------------------------------------
module hsne_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	hsne_cfg_if.sink            cfg,
	output hsne_pkg::grid_cfg_t grid
);
	import hsne_pkg::*;

	dim_t                gx_q;
	dim_t                gy_q;
	dim_t                gz_q;
	idx_t                plane_q;
	logic [2*SIZE_W-1:0] plane_c;

	assign cfg.ready = 1'b1;
	assign plane_c   = gx_q * gy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q    <= dim_t'(GRID_RESET);
			gy_q    <= dim_t'(GRID_RESET);
			gz_q    <= dim_t'(GRID_RESET);
			plane_q <= idx_t'(GRID_RESET * GRID_RESET);
		end else begin
			// plane is registered from the size registers, so it lags a write; only the late stages use it
			plane_q <= plane_c[IDX_W-1:0];
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_GRID_X: gx_q <= sat_dim(cfg.data);
					REG_GRID_Y: gy_q <= sat_dim(cfg.data);
					REG_GRID_Z: gz_q <= sat_dim(cfg.data);
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		grid.gx    = gx_q;
		grid.gy    = gy_q;
		grid.gz    = gz_q;
		grid.plane = plane_q;
		grid.ok    = (gx_q >= dim_t'(MIN_GRID_DIM)) && (gy_q >= dim_t'(MIN_GRID_DIM)) &&
			(gz_q >= dim_t'(MIN_GRID_DIM));
	end

endmodule

### sv/hsne_div_stage.sv
// ----------------------------------------------------------------------------
// hsne_div_stage
// One pipeline stage of the restoring divider: DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module hsne_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hsne_pkg::div_t in_data,
	input  hsne_pkg::dim_t divisor,
	output logic           out_valid,
	input  logic           out_ready,
	output hsne_pkg::div_t out_data
);
	import hsne_pkg::*;

	div_t            step_c [DIV_STEPS+1];
	logic [SIZE_W:0] trial_c [DIV_STEPS];
	logic            valid_s1;
	div_t            data_s1;

	always_comb begin
		step_c[0] = in_data;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial_c[i]  = {step_c[i].rem, step_c[i].dq[IDX_W-1]};
			step_c[i+1] = step_c[i];
			if (trial_c[i] >= {1'b0, divisor}) begin
				step_c[i+1].rem = SIZE_W'(trial_c[i] - {1'b0, divisor});
				step_c[i+1].dq  = {step_c[i].dq[IDX_W-2:0], 1'b1};
			end else begin
				step_c[i+1].rem = trial_c[i][SIZE_W-1:0];
				step_c[i+1].dq  = {step_c[i].dq[IDX_W-2:0], 1'b0};
			end
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= step_c[DIV_STEPS];
		end
	end

endmodule

### sv/hsne_classify.sv
// ----------------------------------------------------------------------------
// hsne_classify
// Inner-cell test and the five row base indices of the half shell.
// ----------------------------------------------------------------------------
module hsne_classify (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hsne_pkg::div_t        in_data,
	input  hsne_pkg::grid_cfg_t   grid,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hsne_pkg::shell_item_t out_item
);
	import hsne_pkg::*;

	// after both divisions: x = idx mod gx, rem = y, dq = z
	dim_t        y_c;
	idx_t        z_c;
	idx_t        gx_c;
	logic        inner_c;
	shell_item_t item_c;
	logic        valid_s1;
	shell_item_t item_s1;

	always_comb begin
		y_c     = in_data.rem;
		z_c     = in_data.dq;
		gx_c    = idx_t'(grid.gx);
		inner_c = grid.ok &&
			(in_data.x != '0) && ({1'b0, in_data.x} + 1'b1 < {1'b0, grid.gx}) &&
			(y_c != '0) && ({1'b0, y_c} + 1'b1 < {1'b0, grid.gy}) &&
			(z_c != '0) && ({1'b0, z_c} + 1'b1 < (IDX_W+1)'(grid.gz));
		item_c.inner       = inner_c;
		item_c.b_self      = in_data.idx;
		item_c.b_up_y      = in_data.idx + gx_c;
		item_c.b_up_z_dn_y = in_data.idx + grid.plane - gx_c;
		item_c.b_up_z      = in_data.idx + grid.plane;
		item_c.b_up_z_up_y = in_data.idx + grid.plane + gx_c;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

### sv/hsne_emit.sv
// ----------------------------------------------------------------------------
// hsne_emit
// Walks the fourteen half-shell slots of an inner cell into the result register; other cells give one result.
// ----------------------------------------------------------------------------
module hsne_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hsne_pkg::shell_item_t in_item,
	hsne_nbr_if.source            rsp
);
	import hsne_pkg::*;

	logic        item_v_q;
	shell_item_t item_q;
	slot_t       slot_q;
	logic        out_v_q;
	idx_t        nb_q;
	slot_t       slot_out_q;
	logic        inner_q;
	logic        last_q;
	shell_step_t step_c;
	idx_t        base_c;
	idx_t        nb_c;
	logic        last_c;
	logic        fire_c;

	always_comb begin
		step_c = shell_step(slot_q);
		case (step_c.row)
			ROW_SELF:      base_c = item_q.b_self;
			ROW_UP_Y:      base_c = item_q.b_up_y;
			ROW_UP_Z_DN_Y: base_c = item_q.b_up_z_dn_y;
			ROW_UP_Z:      base_c = item_q.b_up_z;
			ROW_UP_Z_UP_Y: base_c = item_q.b_up_z_up_y;
			default:       base_c = item_q.b_self;
		endcase
		case (step_c.dx)
			DX_MINUS: nb_c = base_c + '1;
			DX_PLUS:  nb_c = base_c + idx_t'(1);
			default:  nb_c = base_c;
		endcase
		last_c = !item_q.inner || (slot_q == slot_t'(HALF_SHELL_SIZE - 1));
		fire_c = item_v_q && (!out_v_q || rsp.ready);
	end

	assign in_ready = !item_v_q || (fire_c && last_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
			slot_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				item_v_q <= in_valid;
			end
			if (fire_c) begin
				slot_q  <= last_c ? '0 : slot_q + 1'b1;
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= in_item;
		end
		if (fire_c) begin
			nb_q       <= item_q.inner ? nb_c : '0;
			slot_out_q <= item_q.inner ? slot_q : '0;
			inner_q    <= item_q.inner;
			last_q     <= last_c;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.neighbor_index = nb_q;
	assign rsp.slot           = slot_out_q;
	assign rsp.is_inner       = inner_q;
	assign rsp.last           = last_q;

endmodule

### sv/half_shell_neighbor_enumerator_core.sv
// ----------------------------------------------------------------------------
// half_shell_neighbor_enumerator_core
// Link-cell half-shell neighbour list generator for a ghosted 3-D cell grid.
// ----------------------------------------------------------------------------
// Channels: cells carries one linear cell index per transfer; neighbors
// returns its neighbour list, one cell per transfer, with slot, is_inner and
// last. cfg writes grid_size_x/y/z (index 0/1/2) and is always ready; write
// only while no cell is in flight.
// Pipeline: six divider stages, classify stage, slot walker, result register.
// Throughput: an inner cell puts 14 results on the result channel, a ghost
// or out-of-grid cell one; the single result port sets this. Cells are
// taken every cycle until the nine-deep pipeline is full.
// Reset: valid bits clear, all grid sizes return to 3.
// Stall: a result held on neighbors stays stable; the pipeline fills behind
// it and cells.ready drops, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module half_shell_neighbor_enumerator_core (
	input  logic        clk,
	input  logic        arst_n,
	hsne_cfg_if.sink    cfg,
	hsne_cell_if.sink   cells,
	hsne_nbr_if.source  neighbors
);
	import hsne_pkg::*;

	localparam int unsigned NUM_DIV = 2 * DIV_STAGES;

	grid_cfg_t   grid;
	logic        lv   [NUM_DIV+1];
	logic        lr   [NUM_DIV+1];
	div_t        ld   [NUM_DIV+1];
	div_t        tin  [NUM_DIV];
	logic        item_v;
	logic        item_r;
	shell_item_t item;

	hsne_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.grid   (grid)
	);

	assign lv[0]       = cells.valid;
	assign cells.ready = lr[0];

	assign ld[0] = '{idx: cells.cell_index, x: '0, rem: '0, dq: cells.cell_index};

	// second division takes the first quotient; the first remainder becomes x
	always_comb begin
		for (int k = 0; k < NUM_DIV; k++) begin
			tin[k] = ld[k];
			if (k == DIV_STAGES) begin
				tin[k].x   = ld[k].rem;
				tin[k].rem = '0;
			end
		end
	end

	for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
		hsne_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lv[k]),
			.in_ready  (lr[k]),
			.in_data   (tin[k]),
			.divisor   ((k < DIV_STAGES) ? grid.gx : grid.gy),
			.out_valid (lv[k+1]),
			.out_ready (lr[k+1]),
			.out_data  (ld[k+1])
		);
	end

	hsne_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lv[NUM_DIV]),
		.in_ready  (lr[NUM_DIV]),
		.in_data   (ld[NUM_DIV]),
		.grid      (grid),
		.out_valid (item_v),
		.out_ready (item_r),
		.out_item  (item)
	);

	hsne_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_v),
		.in_ready (item_r),
		.in_item  (item),
		.rsp      (neighbors)
	);

endmodule

### sv/hsne_checker.sv
// ----------------------------------------------------------------------------
// hsne_checker
// Port-level checks on the neighbour result stream, bound to the core.
// ----------------------------------------------------------------------------
module hsne_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            nbr_valid,
	input logic            nbr_ready,
	input hsne_pkg::idx_t  nbr_index,
	input hsne_pkg::slot_t nbr_slot,
	input logic            nbr_inner,
	input logic            nbr_last
);
	import hsne_pkg::*;

	slot_t exp_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_slot_q <= '0;
		end else if (nbr_valid && nbr_ready) begin
			exp_slot_q <= nbr_last ? '0 : nbr_slot + 1'b1;
		end
	end

	a_ghost_result: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_valid && !nbr_inner |-> nbr_index == '0 && nbr_slot == '0 && nbr_last)
		else $error("not-inner result malformed");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_valid && nbr_inner |-> nbr_last == (nbr_slot == slot_t'(HALF_SHELL_SIZE - 1)))
		else $error("last mark does not match final slot");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_valid |-> nbr_slot == exp_slot_q)
		else $error("slot sequence broken");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_valid && !nbr_ready |=> nbr_valid &&
			$stable({nbr_index, nbr_slot, nbr_inner, nbr_last}))
		else $error("result changed while stalled");

endmodule

bind half_shell_neighbor_enumerator_core hsne_checker u_hsne_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.nbr_valid (neighbors.valid),
	.nbr_ready (neighbors.ready),
	.nbr_index (neighbors.neighbor_index),
	.nbr_slot  (neighbors.slot),
	.nbr_inner (neighbors.is_inner),
	.nbr_last  (neighbors.last)
);
